// ===== sv/fixed_block_free_list_allocator_defines.svh =====
// Assertion macros shared by the allocator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define FBFL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define FBFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fbfl_pkg.sv =====
package fbfl_pkg;

    localparam int POOL_BLOCKS = 1024;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int GROW_W      = 12;
    localparam int CHUNK_W     = 4;
    localparam int INIT_COUNT  = 16;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [GROW_W-1:0]  grow_t;
    typedef logic [CHUNK_W-1:0] chunk_t;

    // Head value that marks an empty free stack.
    localparam cnt_t   EMPTY_HEAD = cnt_t'(POOL_BLOCKS);
    localparam cnt_t   POOL_CNT   = cnt_t'(POOL_BLOCKS);
    localparam cnt_t   USED_MAX   = {CNT_W{1'b1}};
    localparam chunk_t CHUNK_MAX  = {CHUNK_W{1'b1}};

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NULL      = 2'd3
    } status_t;

    // Write request into the link memory.
    typedef struct packed {
        logic en;
        idx_t addr;
        cnt_t data;
    } link_wr_t;

endpackage

// ===== sv/fbfl_link_ram.sv =====
module fbfl_link_ram (
    input  logic               clk,
    input  fbfl_pkg::link_wr_t wr,
    input  logic               rd_en,
    input  fbfl_pkg::idx_t     rd_addr,
    output fbfl_pkg::cnt_t     rd_data
);

    // One next-link entry per block; contents are meaningful only once written.
    fbfl_pkg::cnt_t mem [fbfl_pkg::POOL_BLOCKS];
    fbfl_pkg::cnt_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/fixed_block_free_list_allocator.sv =====
// A result beat is registered and valid in the cycle after its request is accepted.
// Throughput: one beat per cycle for frees, fresh allocations and rejected requests
// while the result side does not stall; an allocation that pops the free stack holds
// the input side until the new stack head comes back from the link memory read.
// Reset: the pool starts empty with a first chunk of 16 blocks; the link memory is
// not cleared, and writing the configuration register reinitializes the pool.
`include "fixed_block_free_list_allocator_defines.svh"

module fixed_block_free_list_allocator (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration: size of the first chunk.
    input  logic                   cfg_wr_en,
    input  fbfl_pkg::cnt_t         cfg_wr_data,
    // Request channel.
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  fbfl_pkg::idx_t         block_index,
    input  logic                   block_is_null,
    // Result channel.
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output fbfl_pkg::idx_t         granted_index,
    output fbfl_pkg::cnt_t         total_blocks,
    output fbfl_pkg::cnt_t         used_blocks,
    output fbfl_pkg::chunk_t       chunk_total
);

    // The controller either takes beats or waits for the link memory to return
    // the new free stack head after a pop.
    typedef enum logic [1:0] {
        S_READY = 2'b01,
        S_POP   = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    fbfl_pkg::cnt_t    free_head_reg, free_head_next;
    fbfl_pkg::cnt_t    fresh_next_reg, fresh_next_next;
    fbfl_pkg::cnt_t    capacity_reg, capacity_next;
    fbfl_pkg::grow_t   grow_size_reg, grow_size_next;
    fbfl_pkg::cnt_t    used_reg, used_next;
    fbfl_pkg::chunk_t  chunks_reg, chunks_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    fbfl_pkg::idx_t    granted_reg, granted_next;
    fbfl_pkg::cnt_t    total_reg;
    fbfl_pkg::cnt_t    used_out_reg;
    fbfl_pkg::chunk_t  chunk_out_reg;

    logic              in_fire;
    logic              pop_hit;
    logic              need_grow;
    logic              grow_ok;
    logic [12:0]       grow_sum;
    fbfl_pkg::cnt_t    init_count;
    fbfl_pkg::link_wr_t link_wr;
    logic              link_rd_en;
    fbfl_pkg::cnt_t    link_rd_data;

    // The input side stalls while a pop is resolving or while the result
    // register holds a beat that the downstream side is not taking.
    assign in_stall = (state_reg != S_READY) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;

    // A configured first chunk larger than the pool is clamped to the pool.
    assign init_count = (cfg_wr_data > fbfl_pkg::POOL_CNT) ? fbfl_pkg::POOL_CNT : cfg_wr_data;

    assign pop_hit   = (free_head_reg != fbfl_pkg::EMPTY_HEAD);
    assign need_grow = (fresh_next_reg >= capacity_reg);
    assign grow_sum  = {2'b00, capacity_reg} + {1'b0, grow_size_reg};
    assign grow_ok   = (grow_size_reg != '0) && (grow_sum <= 13'(fbfl_pkg::POOL_BLOCKS));

    // Frees push onto the stack by writing the old head into the freed entry.
    // Pops read the link of the current head; that read and a push never share
    // a cycle, since a pop holds the input side until its data has returned.
    always_comb
    begin
        link_wr.en   = 1'b0;
        link_wr.addr = block_index;
        link_wr.data = free_head_reg;
        link_rd_en   = 1'b0;

        state_next      = state_reg;
        free_head_next  = free_head_reg;
        fresh_next_next = fresh_next_reg;
        capacity_next   = capacity_reg;
        grow_size_next  = grow_size_reg;
        used_next       = used_reg;
        chunks_next     = chunks_reg;
        status_next     = fbfl_pkg::ST_OK;
        granted_next    = '0;

        case (state_reg)
            S_READY:
            begin
                if (in_fire)
                begin
                    if (action == fbfl_pkg::ACT_ALLOC)
                    begin
                        if (pop_hit)
                        begin
                            granted_next = free_head_reg[fbfl_pkg::IDX_W-1:0];
                            link_rd_en   = 1'b1;
                            state_next   = S_POP;
                        end
                        else if (!need_grow)
                        begin
                            granted_next    = fresh_next_reg[fbfl_pkg::IDX_W-1:0];
                            fresh_next_next = fresh_next_reg + 1'b1;
                        end
                        else if (grow_ok)
                        begin
                            // The pool takes on a new chunk and the next one doubles.
                            granted_next    = fresh_next_reg[fbfl_pkg::IDX_W-1:0];
                            fresh_next_next = fresh_next_reg + 1'b1;
                            capacity_next   = grow_sum[fbfl_pkg::CNT_W-1:0];
                            if (grow_size_reg <= fbfl_pkg::GROW_W'(fbfl_pkg::POOL_BLOCKS))
                            begin
                                grow_size_next = {grow_size_reg[fbfl_pkg::GROW_W-2:0], 1'b0};
                            end
                            if (chunks_reg != fbfl_pkg::CHUNK_MAX)
                            begin
                                chunks_next = chunks_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            status_next = fbfl_pkg::ST_EXHAUSTED;
                        end

                        if ((status_next == fbfl_pkg::ST_OK) && (used_reg != fbfl_pkg::USED_MAX))
                        begin
                            used_next = used_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (block_is_null)
                        begin
                            status_next = fbfl_pkg::ST_NULL;
                        end
                        else if ({1'b0, block_index} >= capacity_reg)
                        begin
                            status_next = fbfl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            link_wr.en     = 1'b1;
                            free_head_next = {1'b0, block_index};
                            if (used_reg != '0)
                            begin
                                used_next = used_reg - 1'b1;
                            end
                        end
                    end
                end
            end

            S_POP:
            begin
                // The link of the popped block becomes the new stack head.
                free_head_next = link_rd_data;
                state_next     = S_READY;
            end

            default:
            begin
                state_next = S_READY;
            end
        endcase

        // A configuration write restarts the pool; only the user keeps it to idle.
        if (cfg_wr_en)
        begin
            free_head_next  = fbfl_pkg::EMPTY_HEAD;
            fresh_next_next = '0;
            capacity_next   = init_count;
            grow_size_next  = {init_count, 1'b0};
            used_next       = '0;
            chunks_next     = (init_count != '0) ? fbfl_pkg::chunk_t'(1) : '0;
        end
    end

    assign out_valid_next = in_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_READY;
            free_head_reg  <= fbfl_pkg::EMPTY_HEAD;
            fresh_next_reg <= '0;
            capacity_reg   <= fbfl_pkg::cnt_t'(fbfl_pkg::INIT_COUNT);
            grow_size_reg  <= fbfl_pkg::grow_t'(2 * fbfl_pkg::INIT_COUNT);
            used_reg       <= '0;
            chunks_reg     <= fbfl_pkg::chunk_t'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            fresh_next_reg <= fresh_next_next;
            capacity_reg   <= capacity_next;
            grow_size_reg  <= grow_size_next;
            used_reg       <= used_next;
            chunks_reg     <= chunks_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload loads with each accepted beat and holds while stalled.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg    <= status_next;
            granted_reg   <= granted_next;
            total_reg     <= capacity_next;
            used_out_reg  <= used_next;
            chunk_out_reg <= chunks_next;
        end
    end

    fbfl_link_ram u_link_ram (
        .clk     (clk),
        .wr      (link_wr),
        .rd_en   (link_rd_en),
        .rd_addr (free_head_reg[fbfl_pkg::IDX_W-1:0]),
        .rd_data (link_rd_data)
    );

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign total_blocks  = total_reg;
    assign used_blocks   = used_out_reg;
    assign chunk_total   = chunk_out_reg;

    // The stack head is empty or names a block inside the pool.
    `FBFL_ASSERT_ALWAYS(a_head_in_pool,
        (free_head_reg == fbfl_pkg::EMPTY_HEAD) || (free_head_reg < capacity_reg),
        "free stack head lies outside the pool")
    // Fresh indices never run past the pool capacity.
    `FBFL_ASSERT_ALWAYS(a_fresh_bounded, fresh_next_reg <= capacity_reg,
        "fresh index pointer passed capacity")
    // The cycle after an accepted pop finds S_POP with the input side stalled.
    `FBFL_ASSERT_NEXT(a_pop_waits,
        in_fire && (action == fbfl_pkg::ACT_ALLOC) && pop_hit,
        (state_reg == S_POP) && in_stall,
        "pop did not wait for the link read")
    // Every accepted request beat produces a result beat.
    `FBFL_ASSERT_NEXT(a_result_follows, in_fire, out_valid_reg,
        "accepted request produced no result")

endmodule

// ===== test/fixed_block_free_list_allocator_test.sv =====
module fixed_block_free_list_allocator_test;

    // A stretch this long with no beat on either channel means the block hung.
    localparam int WATCHDOG_LIMIT = 1000;

    // What one result beat must carry.
    typedef struct {
        fbfl_pkg::status_t status;
        fbfl_pkg::idx_t    granted;
        fbfl_pkg::cnt_t    total;
        fbfl_pkg::cnt_t    used;
        fbfl_pkg::chunk_t  chunks;
    } pool_result_t;

    logic             clk;
    logic             rst_n         = 1'b0;
    logic             cfg_wr_en     = 1'b0;
    fbfl_pkg::cnt_t   cfg_wr_data   = '0;
    logic             in_valid      = 1'b0;
    logic             in_stall;
    logic             action        = 1'b0;
    fbfl_pkg::idx_t   block_index   = '0;
    logic             block_is_null = 1'b0;
    logic             out_valid;
    logic             out_stall     = 1'b0;
    logic       [1:0] status;
    fbfl_pkg::idx_t   granted_index;
    fbfl_pkg::cnt_t   total_blocks;
    fbfl_pkg::cnt_t   used_blocks;
    fbfl_pkg::chunk_t chunk_total;

    fixed_block_free_list_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .block_index   (block_index),
        .block_is_null (block_is_null),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .granted_index (granted_index),
        .total_blocks  (total_blocks),
        .used_blocks   (used_blocks),
        .chunk_total   (chunk_total)
    );

    // Shadow copy of the allocator. The free stack is a linked list threaded
    // through link_mem, with EMPTY_HEAD marking an empty stack.
    fbfl_pkg::cnt_t   init_count;
    fbfl_pkg::cnt_t   free_head;
    fbfl_pkg::cnt_t   link_mem [fbfl_pkg::POOL_BLOCKS];
    fbfl_pkg::cnt_t   fresh_next;
    fbfl_pkg::cnt_t   capacity;
    fbfl_pkg::grow_t  grow_size;
    fbfl_pkg::cnt_t   used_count;
    fbfl_pkg::chunk_t chunks_added;

    // Results owed by the block, oldest first, and the blocks the stimulus
    // believes it currently holds, so that most frees are well formed.
    pool_result_t   awaited_results [$];
    fbfl_pkg::idx_t held_blocks [$];

    int error_count  = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Any write of the register, and reset, rebuild the pool from scratch.
    // The link memory keeps its contents, but a pop can only read a link
    // written by an earlier free, so the stale entries never matter.
    function automatic void rebuild_pool();
        fbfl_pkg::cnt_t first_chunk;
        first_chunk  = (init_count > fbfl_pkg::POOL_CNT) ? fbfl_pkg::POOL_CNT : init_count;
        free_head    = fbfl_pkg::EMPTY_HEAD;
        fresh_next   = '0;
        capacity     = first_chunk;
        grow_size    = {first_chunk, 1'b0};
        used_count   = '0;
        chunks_added = (first_chunk != 0) ? fbfl_pkg::chunk_t'(1) : fbfl_pkg::chunk_t'(0);
    endfunction

    // Applies one request to the shadow pool and returns the result it owes.
    function automatic pool_result_t step_pool(fbfl_pkg::action_t act,
                                               fbfl_pkg::idx_t idx, logic is_null);
        pool_result_t r;
        r.status  = fbfl_pkg::ST_OK;
        r.granted = '0;
        if (act == fbfl_pkg::ACT_ALLOC)
        begin
            if (free_head != fbfl_pkg::EMPTY_HEAD)
            begin
                // Reuse the most recently freed block first.
                r.granted = fbfl_pkg::idx_t'(free_head);
                free_head = link_mem[r.granted];
            end
            else
            begin
                if (fresh_next >= capacity)
                begin
                    // Fresh indices are used up: add a chunk if it fits.
                    if (grow_size == 0 ||
                        int'(capacity) + int'(grow_size) > fbfl_pkg::POOL_BLOCKS)
                        r.status = fbfl_pkg::ST_EXHAUSTED;
                    else
                    begin
                        capacity = capacity + fbfl_pkg::cnt_t'(grow_size);
                        if (grow_size <= fbfl_pkg::POOL_BLOCKS)
                            grow_size = {grow_size[fbfl_pkg::GROW_W-2:0], 1'b0};
                        if (chunks_added != fbfl_pkg::CHUNK_MAX)
                            chunks_added = chunks_added + 1'b1;
                    end
                end
                if (r.status == fbfl_pkg::ST_OK)
                begin
                    r.granted  = fbfl_pkg::idx_t'(fresh_next);
                    fresh_next = fresh_next + 1'b1;
                end
            end
            if (r.status == fbfl_pkg::ST_OK && used_count != fbfl_pkg::USED_MAX)
                used_count = used_count + 1'b1;
        end
        else if (is_null)
            r.status = fbfl_pkg::ST_NULL;
        else if (fbfl_pkg::cnt_t'(idx) >= capacity)
            r.status = fbfl_pkg::ST_RANGE;
        else
        begin
            // Duplicate frees are not caught: the index is simply pushed again.
            link_mem[idx] = free_head;
            free_head     = fbfl_pkg::cnt_t'(idx);
            if (used_count != 0)
                used_count = used_count - 1'b1;
        end
        r.total  = capacity;
        r.used   = used_count;
        r.chunks = chunks_added;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Sends one request beat, optionally after a random gap, and records
    // the result it must produce once the beat is taken.
    task automatic send_request(input fbfl_pkg::action_t act, input fbfl_pkg::idx_t idx,
                                input logic is_null);
        pool_result_t want;
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        block_index   <= idx;
        block_is_null <= is_null;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = step_pool(act, idx, is_null);
        awaited_results = {awaited_results, want};
        if (act == fbfl_pkg::ACT_ALLOC && want.status == fbfl_pkg::ST_OK)
            held_blocks = {held_blocks, want.granted};
    endtask

    // The register may only change while the block is idle, so every owed
    // result is collected first and the bench then waits out any pending pop.
    task automatic load_initial_count(input fbfl_pkg::cnt_t value);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        init_count = value;
        rebuild_pool();
        held_blocks.delete();
    endtask

    task automatic alloc_block();
        send_request(fbfl_pkg::ACT_ALLOC,
                     fbfl_pkg::idx_t'($urandom_range(0, fbfl_pkg::POOL_BLOCKS - 1)),
                     1'($urandom_range(0, 1)));
    endtask

    // Mostly well-formed traffic: allocations and frees of blocks that are
    // held. A slice of noise frees null blocks or arbitrary indices, which
    // covers out-of-range and duplicate frees.
    task automatic random_requests(input int count, input int alloc_pct);
        int roll;
        int pick;
        fbfl_pkg::idx_t blk;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
                send_request(fbfl_pkg::ACT_FREE,
                             fbfl_pkg::idx_t'($urandom_range(0, fbfl_pkg::POOL_BLOCKS - 1)),
                             1'($urandom_range(0, 1)));
            else if (held_blocks.size() == 0 || $urandom_range(0, 99) < alloc_pct)
                alloc_block();
            else
            begin
                pick = $urandom_range(0, held_blocks.size() - 1);
                blk  = held_blocks[pick];
                held_blocks.delete(pick);
                send_request(fbfl_pkg::ACT_FREE, blk, 1'b0);
            end
        end
    endtask

    // Default first chunk of 16: fresh grants, every kind of rejected free,
    // last-in first-out reuse, and a duplicate free handed out twice.
    task automatic test_default_pool();
        send_request(fbfl_pkg::ACT_ALLOC, '1, 1'b1);
        send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
        send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
        send_request(fbfl_pkg::ACT_FREE, '1, 1'b1);
        send_request(fbfl_pkg::ACT_FREE, fbfl_pkg::idx_t'(16), 1'b0);
        send_request(fbfl_pkg::ACT_FREE, '1, 1'b0);
        send_request(fbfl_pkg::ACT_FREE, fbfl_pkg::idx_t'(1), 1'b0);
        send_request(fbfl_pkg::ACT_FREE, '0, 1'b0);
        send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
        send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
        send_request(fbfl_pkg::ACT_FREE, fbfl_pkg::idx_t'(2), 1'b0);
        send_request(fbfl_pkg::ACT_FREE, fbfl_pkg::idx_t'(2), 1'b0);
        send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
        send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
    endtask

    // A first chunk of one block makes the pool grow by 2, 4, ... in turn.
    task automatic test_chunk_growth();
        load_initial_count(fbfl_pkg::cnt_t'(1));
        repeat (8) send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
    endtask

    // With a first chunk of zero nothing can ever be granted.
    task automatic test_zero_count();
        load_initial_count('0);
        send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
        send_request(fbfl_pkg::ACT_FREE, '0, 1'b0);
        send_request(fbfl_pkg::ACT_FREE, '0, 1'b1);
    endtask

    // The widest register value saturates to the full pool, so the top
    // index is in range and can be freed and reused without being granted.
    task automatic test_saturated_count();
        load_initial_count('1);
        send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
        send_request(fbfl_pkg::ACT_FREE, '1, 1'b0);
        send_request(fbfl_pkg::ACT_ALLOC, '0, 1'b0);
    endtask

    // Several register settings with their own mixes and varied idling. A first
    // chunk of 350 with heavy allocation runs the pool dry.
    task automatic test_random_traffic();
        in_idle_pct  = 20;
        out_idle_pct = 15;
        load_initial_count(fbfl_pkg::cnt_t'(1));
        random_requests(400, 70);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        load_initial_count(fbfl_pkg::cnt_t'(350));
        random_requests(450, 88);
        in_idle_pct  = 35;
        out_idle_pct = 30;
        load_initial_count(fbfl_pkg::cnt_t'(fbfl_pkg::INIT_COUNT));
        random_requests(200, 50);
        in_idle_pct  = 10;
        out_idle_pct = 5;
        load_initial_count(fbfl_pkg::cnt_t'($urandom_range(0, 2047)));
        random_requests(150, 60);
        load_initial_count(fbfl_pkg::POOL_CNT);
        random_requests(150, 65);
        load_initial_count('0);
        random_requests(40, 60);
    endtask

    // The last stretch runs with no gaps on either side.
    task automatic test_quiet_finish();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        load_initial_count(fbfl_pkg::cnt_t'(3));
        random_requests(200, 65);
    endtask

    initial
    begin
        init_count = fbfl_pkg::cnt_t'(fbfl_pkg::INIT_COUNT);
        rebuild_pool();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_default_pool();
        test_chunk_growth();
        test_zero_count();
        test_saturated_count();
        test_random_traffic();
        test_quiet_finish();

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side stalls in bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct)
            stall_left = $urandom_range(1, 6);
        out_stall <= (stall_left > 0);
    end

    // Each accepted result beat is checked against the oldest owed result.
    always @(posedge clk)
    begin
        pool_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                flag_error($sformatf("result beat with nothing owed, status %0d", status));
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("status %0d, expected %0d", status, want.status));
                if (granted_index !== want.granted)
                    flag_error($sformatf("granted_index %0d, expected %0d",
                                         granted_index, want.granted));
                if (total_blocks !== want.total)
                    flag_error($sformatf("total_blocks %0d, expected %0d",
                                         total_blocks, want.total));
                if (used_blocks !== want.used)
                    flag_error($sformatf("used_blocks %0d, expected %0d",
                                         used_blocks, want.used));
                if (chunk_total !== want.chunks)
                    flag_error($sformatf("chunk_total %0d, expected %0d",
                                         chunk_total, want.chunks));
            end
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no beat accepted for %0d cycles", $realtime, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
